### rtl/core/hash_table_chaining_without_replacement_unit_macros.svh
// assertion macros used by the checker file
`ifndef HASH_TABLE_CHAINING_WITHOUT_REPLACEMENT_UNIT_MACROS_SVH
`define HASH_TABLE_CHAINING_WITHOUT_REPLACEMENT_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HTCWR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define HTCWR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/htcwr_pkg.sv
package htcwr_pkg;

  // table geometry, fixed by the 4-bit slot fields
  localparam int TABLE_SIZE = 16;
  localparam int SLOT_W     = 4;
  localparam int COUNT_W    = 5;

  // field widths
  localparam int KEY_W     = 34;
  localparam int PAYLOAD_W = 64;
  localparam int DATA_W    = KEY_W + PAYLOAD_W;

  // stream widths
  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 112;
  localparam int M_TUSER_W = 2;

  // default depth of the command queue
  localparam int QUEUE_DEPTH_DEF = 2;

  // result status codes
  localparam logic [M_TUSER_W-1:0] STATUS_INSERTED = 2'd0;
  localparam logic [M_TUSER_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [M_TUSER_W-1:0] STATUS_READ     = 2'd2;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_kind_t;

  // classified command between front and back
  typedef struct packed {
    cmd_kind_t              kind;
    logic [SLOT_W-1:0]      slot;     // home slot for insert, read slot for read
    logic [KEY_W-1:0]       key;
    logic [PAYLOAD_W-1:0]   payload;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic [M_TUSER_W-1:0]   status;
    logic [SLOT_W-1:0]      slot;
    logic                   entry_valid;
    logic [KEY_W-1:0]       entry_key;
    logic [PAYLOAD_W-1:0]   entry_payload;
    logic                   entry_has_next;
    logic [SLOT_W-1:0]      entry_next;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ_WAIT,
    BK_HOME_WAIT,
    BK_WALK,
    BK_WALK_WAIT,
    BK_PROBE
  } back_state_t;

endpackage

### rtl/core/hash_table_chaining_without_replacement_unit.sv
// channel  dir  tdata (low bit up)                                    tuser      tlast
// s_*      in   key[33:0] payload[97:34] slot_index[101:98] pad       operation  -
// m_*      out  slot[3:0] entry_valid[4] entry_key[38:5]              status     -
//               entry_payload[102:39] entry_has_next[103]
//               entry_next[107:104] pad
//
// a beat passes through the front holding stage and then the queue
// back end: a read waits on the registered RAM read; an insert to an empty home or a
// rejected insert completes in idle; an insert behind an occupied home reads the home,
// then probes slot by slot, after first walking the chain link by link on a synonym
// chain walk steps read the next-slot RAM; probe steps test only the slot flags
// reset clears slot flags and the fill count at once, no clearing pass
// input keeps accepting into the queue, until it fills, while a result waits on m_tready
module hash_table_chaining_without_replacement_unit import htcwr_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // key, payload, slot_index
  input  logic                 s_tuser,  // operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // slot, entry_valid, entry_key, entry_payload,
                                         // entry_has_next, entry_next
  output logic [M_TUSER_W-1:0] m_tuser   // status
);

  localparam int PACK_W = SLOT_W + 1 + KEY_W + PAYLOAD_W + 1 + SLOT_W;

  logic    fr_valid;
  logic    fr_ready;
  cmd_t    fr_cmd;
  logic    q_valid;
  logic    q_ready;
  cmd_t    q_cmd;
  result_t res;

  htcwr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_data   (s_tdata),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  htcwr_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_cmd)
  );

  htcwr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_in    (q_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // pack the result beat
  assign m_tuser = res.status;
  assign m_tdata = {{(M_TDATA_W - PACK_W){1'b0}}, res.entry_next, res.entry_has_next,
                    res.entry_payload, res.entry_key, res.entry_valid, res.slot};

endmodule

### rtl/core/htcwr_ram.sv
module htcwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/htcwr_front.sv
module htcwr_front import htcwr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [S_TDATA_W-1:0] in_data,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd
);

  logic hold_valid;
  cmd_t hold;
  cmd_t classified;
  logic [KEY_W-1:0]     f_key;
  logic [PAYLOAD_W-1:0] f_payload;
  logic [SLOT_W-1:0]    f_index;

  // unpack the beat
  assign f_key     = in_data[KEY_W-1:0];
  assign f_payload = in_data[KEY_W+PAYLOAD_W-1:KEY_W];
  assign f_index   = in_data[KEY_W+PAYLOAD_W+SLOT_W-1:KEY_W+PAYLOAD_W];

  // classify: insert slot is the home slot, the key mod the table size; read slot is slot_index
  always_comb begin
    classified.kind    = in_op ? CMD_READ : CMD_INSERT;
    classified.key     = f_key;
    classified.payload = f_payload;
    classified.slot    = in_op ? f_index : f_key[SLOT_W-1:0];
  end

  assign in_ready  = !hold_valid || cmd_ready;
  assign cmd_valid = hold_valid;
  assign cmd       = hold;

  // holding stage in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= classified;
    end
  end

endmodule

### rtl/core/htcwr_fifo.sv
module htcwr_fifo import htcwr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign in_ready  = fill != CNT_W'(DEPTH);
  assign out_valid = fill != '0;
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

### rtl/core/htcwr_back.sv
module htcwr_back import htcwr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  cmd_t    cmd_in,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  back_state_t       state, state_next;
  cmd_t              cmd;
  logic [SLOT_W-1:0] tail, tail_next;
  logic [SLOT_W-1:0] pos, pos_next;
  logic [COUNT_W-1:0] steps, steps_next;
  logic              link, link_next;
  logic [TABLE_SIZE-1:0] valid_bits;
  logic [TABLE_SIZE-1:0] has_next_bits;
  logic [COUNT_W-1:0] count;

  logic              out_free;
  logic              out_load;
  result_t           res_next;
  logic              store_en;
  logic [SLOT_W-1:0] store_pos;
  logic [DATA_W-1:0] store_data;
  logic              link_en;
  logic [SLOT_W-1:0] data_raddr;
  logic [SLOT_W-1:0] next_raddr;
  logic [DATA_W-1:0] data_rdata;
  logic [SLOT_W-1:0] next_rdata;
  logic              rd_valid;
  logic              rd_has_next;

  assign out_free = !out_valid || out_ready;

  // key and payload per slot
  htcwr_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SIZE)) u_data_ram (
    .clk   (clk),
    .we    (store_en),
    .waddr (store_pos),
    .wdata (store_data),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  // chain successor per slot, written at the tail when linking
  htcwr_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SIZE)) u_next_ram (
    .clk   (clk),
    .we    (link_en),
    .waddr (tail),
    .wdata (store_pos),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

  assign rd_valid    = valid_bits[cmd.slot];
  assign rd_has_next = rd_valid && has_next_bits[cmd.slot];

  // next state and control
  always_comb begin
    state_next = state;
    tail_next  = tail;
    pos_next   = pos;
    steps_next = steps;
    link_next  = link;
    cmd_ready  = 1'b0;
    out_load   = 1'b0;
    res_next   = '0;
    store_en   = 1'b0;
    store_pos  = pos;
    store_data = {cmd.payload, cmd.key};
    link_en    = 1'b0;
    data_raddr = '0;
    next_raddr = '0;
    case (state)
      BK_IDLE: begin
        data_raddr = cmd_in.slot;
        next_raddr = cmd_in.slot;
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          if (cmd_in.kind == CMD_READ) begin
            state_next = BK_READ_WAIT;
          end else if (count >= COUNT_W'(TABLE_SIZE)) begin
            // table full: reject, nothing changes
            out_load        = 1'b1;
            res_next.status = STATUS_FULL;
          end else if (!valid_bits[cmd_in.slot]) begin
            // empty home slot: store directly from the incoming command
            store_en        = 1'b1;
            store_pos       = cmd_in.slot;
            store_data      = {cmd_in.payload, cmd_in.key};
            out_load        = 1'b1;
            res_next.status = STATUS_INSERTED;
            res_next.slot   = cmd_in.slot;
          end else begin
            state_next = BK_HOME_WAIT;
          end
        end
      end
      BK_READ_WAIT: begin
        out_load                = 1'b1;
        res_next.status         = STATUS_READ;
        res_next.slot           = cmd.slot;
        res_next.entry_valid    = rd_valid;
        res_next.entry_key      = rd_valid ? data_rdata[KEY_W-1:0] : '0;
        res_next.entry_payload  = rd_valid ? data_rdata[DATA_W-1:KEY_W] : '0;
        res_next.entry_has_next = rd_has_next;
        res_next.entry_next     = rd_has_next ? next_rdata : '0;
        state_next              = BK_IDLE;
      end
      BK_HOME_WAIT: begin
        // synonym when the resident key shares the home slot
        if (data_rdata[SLOT_W-1:0] == cmd.slot) begin
          tail_next  = cmd.slot;
          steps_next = '0;
          link_next  = 1'b1;
          state_next = BK_WALK;
        end else begin
          pos_next   = cmd.slot;
          link_next  = 1'b0;
          state_next = BK_PROBE;
        end
      end
      BK_WALK: begin
        next_raddr = tail;
        if (has_next_bits[tail] && steps != COUNT_W'(TABLE_SIZE)) begin
          state_next = BK_WALK_WAIT;
        end else begin
          pos_next   = tail;
          state_next = BK_PROBE;
        end
      end
      BK_WALK_WAIT: begin
        tail_next  = next_rdata;
        steps_next = steps + 1'b1;
        state_next = BK_WALK;
      end
      BK_PROBE: begin
        // linear probe, one slot per cycle; a free slot exists
        if (!valid_bits[pos]) begin
          store_en        = 1'b1;
          link_en         = link;
          out_load        = 1'b1;
          res_next.status = STATUS_INSERTED;
          res_next.slot   = pos;
          state_next      = BK_IDLE;
        end else begin
          pos_next = (pos == SLOT_W'(TABLE_SIZE - 1)) ? '0 : pos + 1'b1;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // control registers and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      valid_bits    <= '0;
      has_next_bits <= '0;
      count         <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (store_en) begin
        valid_bits[store_pos]    <= 1'b1;
        has_next_bits[store_pos] <= 1'b0;
        count                    <= count + 1'b1;
      end
      if (link_en) begin
        has_next_bits[tail] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    tail  <= tail_next;
    pos   <= pos_next;
    steps <= steps_next;
    link  <= link_next;
    if (cmd_ready) begin
      cmd <= cmd_in;
    end
    if (out_load) begin
      out_res <= res_next;
    end
  end

endmodule

### rtl/core/htcwr_checker.sv
`include "hash_table_chaining_without_replacement_unit_macros.svh"

module htcwr_checker import htcwr_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic                 s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser
);

  // a stalled result beat holds
  `HTCWR_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed under stall")

  // insert and reject beats carry no entry contents
  `HTCWR_ASSERT_NOW(a_insert_no_entry, clk, rst, m_tvalid && m_tuser != STATUS_READ, m_tdata[107:4] == '0, "entry fields set on insert result")

  // a rejected insert reports slot zero
  `HTCWR_ASSERT_NOW(a_full_slot_zero, clk, rst, m_tvalid && m_tuser == STATUS_FULL, m_tdata[3:0] == '0, "full result with nonzero slot")

  // an empty slot reads back with all entry fields zero
  `HTCWR_ASSERT_NOW(a_empty_read_zero, clk, rst, m_tvalid && m_tuser == STATUS_READ && !m_tdata[4], m_tdata[107:5] == '0, "empty slot read with nonzero fields")

endmodule

bind hash_table_chaining_without_replacement_unit htcwr_checker u_checker (.*);

### bench/hash_table_chaining_without_replacement_unit_tb.sv
`timescale 1ns / 1ps

module hash_table_chaining_without_replacement_unit_tb;
  import htcwr_pkg::*;

  localparam int RANDOM_CMDS    = 1030;
  localparam int PHASE_LEN      = 64;
  localparam int HOLDOFF_AT     = 300;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_AT       = 500;
  localparam int TAIL_CYCLES    = 64;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int PAD_W          = S_TDATA_W - SLOT_W - PAYLOAD_W - KEY_W;

  // idle phases, stepped through as beats are accepted
  localparam logic [1:0] PH_FREE       = 2'd0;
  localparam logic [1:0] PH_SEND_IDLE  = 2'd1;
  localparam logic [1:0] PH_RECV_STALL = 2'd2;
  localparam logic [1:0] PH_BOTH       = 2'd3;

  typedef struct {
    cmd_kind_t              op;
    logic [KEY_W-1:0]       key;
    logic [PAYLOAD_W-1:0]   payload;
    logic [SLOT_W-1:0]      idx;
    bit                     drain_first;
  } table_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  table_cmd_t pending_cmds[$];
  result_t    expected_results[$];

  // shadow copy of the slot table
  logic                 tbl_valid    [TABLE_SIZE];
  logic [KEY_W-1:0]     tbl_key      [TABLE_SIZE];
  logic [PAYLOAD_W-1:0] tbl_payload  [TABLE_SIZE];
  logic                 tbl_has_next [TABLE_SIZE];
  logic [SLOT_W-1:0]    tbl_next     [TABLE_SIZE];
  int                   fill_count;

  int n_accepted = 0;
  int n_received = 0;
  int err_count = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  int cycle_count = 0;
  logic [1:0] idle_phase;

  assign idle_phase = 2'((n_accepted / PHASE_LEN) % 4);

  hash_table_chaining_without_replacement_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // key, payload, slot_index
    .s_tuser  (s_tuser),   // operation
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // slot, entry_valid, entry_key, entry_payload,
                           // entry_has_next, entry_next
    .m_tuser  (m_tuser)    // status
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // first empty slot at or after start, wrapping
  function automatic logic [SLOT_W-1:0] first_free(input logic [SLOT_W-1:0] start);
    logic [SLOT_W-1:0] pos;
    pos = start;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      if (!tbl_valid[pos]) break;
      pos = SLOT_W'((pos + 1) % TABLE_SIZE);
    end
    return pos;
  endfunction

  // apply one command to the shadow table and return the beat it should produce
  function automatic result_t apply_cmd(input table_cmd_t c);
    result_t           r;
    logic [SLOT_W-1:0] home;
    logic [SLOT_W-1:0] pos;
    logic [SLOT_W-1:0] tail;
    bit                chained;
    r = '0;
    if (c.op == CMD_READ) begin
      r.status = STATUS_READ;
      r.slot = c.idx;
      if (tbl_valid[c.idx]) begin
        r.entry_valid = 1'b1;
        r.entry_key = tbl_key[c.idx];
        r.entry_payload = tbl_payload[c.idx];
        if (tbl_has_next[c.idx]) begin
          r.entry_has_next = 1'b1;
          r.entry_next = tbl_next[c.idx];
        end
      end
      return r;
    end
    if (fill_count >= TABLE_SIZE) begin
      r.status = STATUS_FULL;
      return r;
    end
    home = SLOT_W'(c.key % TABLE_SIZE);
    chained = 1'b0;
    tail = home;
    if (!tbl_valid[home]) begin
      pos = home;
    end else if (SLOT_W'(tbl_key[home] % TABLE_SIZE) == home) begin
      // synonym at home: follow its chain to the tail, then probe onward
      for (int n = 0; n < TABLE_SIZE && tbl_has_next[tail]; n++)
        tail = tbl_next[tail];
      pos = first_free(tail);
      chained = 1'b1;
    end else begin
      // home taken by a foreign key: probe, no link
      pos = first_free(home);
    end
    tbl_valid[pos] = 1'b1;
    tbl_key[pos] = c.key;
    tbl_payload[pos] = c.payload;
    tbl_has_next[pos] = 1'b0;
    tbl_next[pos] = '0;
    fill_count++;
    if (chained) begin
      tbl_has_next[tail] = 1'b1;
      tbl_next[tail] = pos;
    end
    r.status = STATUS_INSERTED;
    r.slot = pos;
    return r;
  endfunction

  function automatic bit sender_idles(input logic [1:0] ph);
    return (ph == PH_SEND_IDLE && $urandom_range(99) < 88) ||
           (ph == PH_BOTH && $urandom_range(99) < 37);
  endfunction

  function automatic bit receiver_stalls(input logic [1:0] ph);
    return (ph == PH_RECV_STALL && $urandom_range(99) < 88) ||
           (ph == PH_BOTH && $urandom_range(99) < 37);
  endfunction

  task automatic add_insert(input logic [KEY_W-1:0] key, input logic [PAYLOAD_W-1:0] payload,
                            input bit drain);
    table_cmd_t c;
    c.op = CMD_INSERT;
    c.key = key;
    c.payload = payload;
    c.idx = SLOT_W'($urandom_range(TABLE_SIZE - 1));
    c.drain_first = drain;
    pending_cmds.push_back(c);
  endtask

  task automatic add_read(input logic [SLOT_W-1:0] idx, input bit drain);
    table_cmd_t c;
    c.op = CMD_READ;
    c.key = KEY_W'({$urandom, $urandom});
    c.payload = {$urandom, $urandom};
    c.idx = idx;
    c.drain_first = drain;
    pending_cmds.push_back(c);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h, got %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // driver: offers the head of the pending list, predicts on acceptance
  always @(posedge clk) begin : drive
    table_cmd_t head;
    bit         fire;
    int         outstanding;
    if (!rst) begin
      fire = s_tvalid && s_tready;
      if (fire) begin
        expected_results.push_back(apply_cmd(pending_cmds.pop_front()));
        n_accepted <= n_accepted + 1;
      end
      if (!(s_tvalid && !fire)) begin
        outstanding = n_accepted + int'(fire) - n_received;
        if (pending_cmds.size() != 0) begin
          head = pending_cmds[0];
          if ((head.drain_first && outstanding != 0) ||
              (holdoff_left == 0 && sender_idles(idle_phase))) begin
            s_tvalid <= 1'b0;
          end else begin
            s_tvalid <= 1'b1;
            s_tdata <= {{PAD_W{1'b0}}, head.idx, head.payload, head.key};
            s_tuser <= head.op;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, partway through the run
  always @(posedge clk) begin
    if (!rst) begin
      if (!holdoff_done && n_accepted >= HOLDOFF_AT) begin
        holdoff_left <= HOLDOFF_CYCLES;
        holdoff_done <= 1'b1;
      end else if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
      end
    end
  end

  // monitor: compare every result beat with the oldest prediction
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        n_received <= n_received + 1;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result beat: status %0h tdata %0h", $time, m_tuser,
                   m_tdata);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(want.status), 64'(m_tuser));
          check_field("slot", 64'(want.slot), 64'(m_tdata[3:0]));
          check_field("entry_valid", 64'(want.entry_valid), 64'(m_tdata[4]));
          check_field("entry_key", 64'(want.entry_key), 64'(m_tdata[38:5]));
          check_field("entry_payload", want.entry_payload, m_tdata[102:39]);
          check_field("entry_has_next", 64'(want.entry_has_next), 64'(m_tdata[103]));
          check_field("entry_next", 64'(want.entry_next), 64'(m_tdata[107:104]));
        end
      end
      m_tready <= (holdoff_left == 0) && !receiver_stalls(idle_phase);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] k;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_payload[i] = '0;
      tbl_has_next[i] = 1'b0;
      tbl_next[i] = '0;
    end
    fill_count = 0;

    // directed: empty reads, chains, foreign homes, wrap, duplicate key
    add_read(4'd0, 1'b0);
    add_read(4'd15, 1'b0);
    add_insert(34'd0, {PAYLOAD_W{1'b1}}, 1'b0);
    add_insert(34'd16, '0, 1'b0);                    // synonym of slot 0
    add_insert(34'd32, 64'h0123_4567_89ab_cdef, 1'b0);  // chain grows to 3
    add_insert({KEY_W{1'b1}}, '0, 1'b0);             // largest key, home 15
    add_insert(34'h3_ffff_fff1, 64'h8000_0000_0000_0001, 1'b0);  // home holds foreign key
    add_insert(34'd31, 64'hfedc_ba98_7654_3210, 1'b0);  // probe wraps past slot 15
    add_insert(34'd16, 64'h5555_aaaa_5555_aaaa, 1'b0);  // duplicate key
    add_insert(34'd4, 64'haaaa_5555_aaaa_5555, 1'b0);   // home taken by another chain
    for (int i = 0; i < 7; i++)
      add_read(SLOT_W'(i), 1'b0);
    add_read(4'd15, 1'b0);
    add_read(4'd9, 1'b0);

    // random: inserts mostly aimed at a few homes until full, then rejects; reads throughout
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if ($urandom_range(99) < 40) begin
        k = KEY_W'({$urandom, $urandom});
        case ($urandom_range(3))
          0: k[SLOT_W-1:0] = 4'd0;
          1: k[SLOT_W-1:0] = 4'd15;
          2: k[SLOT_W-1:0] = SLOT_W'($urandom_range(7, 8));
          default: ;
        endcase
        add_insert(k, {$urandom, $urandom}, i == DRAIN_AT);
      end else begin
        add_read(SLOT_W'($urandom_range(TABLE_SIZE - 1)), i == DRAIN_AT);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t %0d results never arrived", $time, expected_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/htcwr_pkg.sv
rtl/core/htcwr_ram.sv
rtl/core/htcwr_front.sv
rtl/core/htcwr_fifo.sv
rtl/core/htcwr_back.sv
rtl/core/hash_table_chaining_without_replacement_unit.sv
rtl/core/htcwr_checker.sv
bench/hash_table_chaining_without_replacement_unit_tb.sv
